// File: src/srfp_pkg.sv
// Shared constants and types for the SLIP response frame parser.
`timescale 1ns / 1ps

package srfp_pkg;

   localparam logic [7:0] SLIP_END     = 8'hC0;
   localparam logic [7:0] SLIP_ESC     = 8'hDB;
   localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;
   localparam logic [7:0] SLIP_ESC_END = 8'hDC;
   localparam logic [7:0] DIR_RESPONSE = 8'h01;
   localparam logic [7:0] OPC_SYNC     = 8'h08;

   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_DIRECTION   = 3'd1;
   localparam logic [2:0] ERR_OPCODE      = 3'd2;
   localparam logic [2:0] ERR_STATUS      = 3'd3;
   localparam logic [2:0] ERR_ESCAPE      = 3'd4;
   localparam logic [2:0] ERR_SHORT_LEN   = 3'd5;

   localparam logic [0:0] KIND_PAYLOAD = 1'b0;
   localparam logic [0:0] KIND_VERDICT = 1'b1;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam logic [0:0] REG_EXPECTED_OPCODE = 1'b0;
   localparam logic [0:0] REG_STUB_RUNNING    = 1'b1;

   typedef struct packed {
      logic [7:0] expected_opcode;
      logic       stub_running;
   } cfg_type;

   typedef struct packed {
      logic        out_kind;
      logic [7:0]  payload_byte;
      logic [31:0] reg_data;
      logic        response_ok;
      logic [2:0]  error_code;
      logic [7:0]  error_detail;
   } rsp_type;

endpackage

// File: src/srfp_if.sv
// Valid/ready channel interfaces for received bytes and parser results.
`timescale 1ns / 1ps

interface srfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface srfp_rsp_if;
   logic        valid;
   logic        ready;
   logic        out_kind;
   logic [7:0]  payload_byte;
   logic [31:0] reg_data;
   logic        response_ok;
   logic [2:0]  error_code;
   logic [7:0]  error_detail;

   modport source (output valid, output out_kind, output payload_byte, output reg_data,
                   output response_ok, output error_code, output error_detail,
                   input ready);
   modport sink   (input valid, input out_kind, input payload_byte, input reg_data,
                   input response_ok, input error_code, input error_detail,
                   output ready);
endinterface

// File: src/srfp_csr.sv
// APB-style configuration registers: expected opcode and stub flag.
`timescale 1ns / 1ps

module srfp_csr
   import srfp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   logic [7:0] expected_opcode_ff, expected_opcode_in;
   logic       stub_running_ff, stub_running_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      expected_opcode_in = expected_opcode_ff;
      stub_running_in    = stub_running_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_EXPECTED_OPCODE: expected_opcode_in = pwdata[7:0];
            REG_STUB_RUNNING:    stub_running_in    = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_opcode_ff <= 8'h00;
         stub_running_ff    <= 1'b0;
      end else begin
         expected_opcode_ff <= expected_opcode_in;
         stub_running_ff    <= stub_running_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_EXPECTED_OPCODE: prdata = {24'h000000, expected_opcode_ff};
         REG_STUB_RUNNING:    prdata = {31'h00000000, stub_running_ff};
         default:             prdata = 32'h00000000;
      endcase
   end

   assign cfg.expected_opcode = expected_opcode_ff;
   assign cfg.stub_running    = stub_running_ff;

endmodule

// File: src/srfp_core.sv
// Frame state machine: SLIP unescape, header/payload/status tracking, verdicts.
`timescale 1ns / 1ps

module srfp_core
   import srfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   input  cfg_type    cfg,
   output logic       res_valid,
   output rsp_type    res
);

   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_HEADER  = 3'd1;
   localparam logic [2:0] PH_PAYLOAD = 3'd2;
   localparam logic [2:0] PH_STATUS  = 3'd3;
   localparam logic [2:0] PH_CLOSE   = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic        esc_ff, esc_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [7:0]  dir_ff, dir_in;
   logic [7:0]  opc_ff, opc_in;
   logic [15:0] len_ff, len_in;
   logic [31:0] reg_word_ff, reg_word_in;
   logic [7:0]  stat1_ff, stat1_in;
   logic [7:0]  stat2_ff, stat2_in;
   logic        rom_ff, rom_in;
   logic        short_ff, short_in;

   logic        data_ok;
   logic [7:0]  db;
   logic        verdict;
   logic [2:0]  code;
   logic        hdr_short;
   logic [15:0] hdr_slen;
   logic [15:0] slen;
   logic [15:0] plen;
   logic [15:0] cnt_inc;

   assign slen    = short_ff ? 16'd2 : 16'd4;
   assign plen    = len_ff - slen;
   assign cnt_inc = cnt_ff + 16'd1;

   always_comb begin
      phase_in    = phase_ff;
      esc_in      = esc_ff;
      cnt_in      = cnt_ff;
      dir_in      = dir_ff;
      opc_in      = opc_ff;
      len_in      = len_ff;
      reg_word_in = reg_word_ff;
      stat1_in    = stat1_ff;
      stat2_in    = stat2_ff;
      rom_in      = rom_ff;
      short_in    = short_ff;
      data_ok     = 1'b0;
      db          = rx_byte;
      verdict     = 1'b0;
      code        = ERR_NONE;
      hdr_short   = 1'b0;
      hdr_slen    = 16'd4;
      res_valid   = 1'b0;
      res         = '0;

      case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == SLIP_END) begin
               phase_in    = PH_HEADER;
               esc_in      = 1'b0;
               cnt_in      = 16'd0;
               dir_in      = 8'h00;
               opc_in      = 8'h00;
               len_in      = 16'h0000;
               reg_word_in = 32'h00000000;
               stat1_in    = 8'h00;
               stat2_in    = 8'h00;
            end
         end
         PH_CLOSE: begin
            if (rx_byte == SLIP_END) begin
               verdict = 1'b1;
               if (dir_ff != DIR_RESPONSE) begin
                  code = ERR_DIRECTION;
               end else if (opc_ff != cfg.expected_opcode) begin
                  code = ERR_OPCODE;
               end else if (stat1_ff != 8'h00 || stat2_ff != 8'h00) begin
                  code = ERR_STATUS;
               end
            end
         end
         PH_HEADER, PH_PAYLOAD, PH_STATUS: begin
            if (esc_ff) begin
               esc_in = 1'b0;
               if (rx_byte == SLIP_ESC_ESC) begin
                  db      = SLIP_ESC;
                  data_ok = 1'b1;
               end else if (rx_byte == SLIP_ESC_END) begin
                  db      = SLIP_END;
                  data_ok = 1'b1;
               end else begin
                  verdict = 1'b1;
                  code    = ERR_ESCAPE;
               end
            end else if (rx_byte == SLIP_ESC) begin
               esc_in = 1'b1;
            end else begin
               data_ok = 1'b1;
            end

            if (data_ok) begin
               case (phase_ff)
                  PH_HEADER: begin
                     case (cnt_ff[2:0])
                        3'd0: dir_in = db;
                        3'd1: opc_in = db;
                        3'd2: len_in = {len_ff[15:8], db};
                        3'd3: len_in = {db, len_ff[7:0]};
                        3'd4: reg_word_in = {reg_word_ff[31:8], db};
                        3'd5: reg_word_in = {reg_word_ff[31:16], db, reg_word_ff[7:0]};
                        3'd6: reg_word_in = {reg_word_ff[31:24], db, reg_word_ff[15:0]};
                        default: reg_word_in = {db, reg_word_ff[23:0]};
                     endcase
                     cnt_in = cnt_inc;
                     if (cnt_ff[2:0] == 3'd7) begin
                        cnt_in    = 16'd0;
                        // sync reply shorter than the expected status reveals the short-status ROM
                        hdr_short = cfg.stub_running || rom_ff;
                        hdr_slen  = hdr_short ? 16'd2 : 16'd4;
                        if (cfg.expected_opcode == OPC_SYNC && len_in < hdr_slen) begin
                           rom_in    = 1'b1;
                           hdr_short = 1'b1;
                           hdr_slen  = 16'd2;
                        end
                        short_in = hdr_short;
                        if (len_in < hdr_slen) begin
                           verdict = 1'b1;
                           code    = ERR_SHORT_LEN;
                        end else if (len_in == hdr_slen) begin
                           phase_in = PH_STATUS;
                        end else begin
                           phase_in = PH_PAYLOAD;
                        end
                     end
                  end
                  PH_PAYLOAD: begin
                     cnt_in = cnt_inc;
                     if (cnt_inc >= plen) begin
                        cnt_in   = 16'd0;
                        phase_in = PH_STATUS;
                     end
                     res_valid        = 1'b1;
                     res.out_kind     = KIND_PAYLOAD;
                     res.payload_byte = db;
                  end
                  default: begin
                     if (cnt_ff == 16'd0) begin
                        stat1_in = db;
                     end else if (cnt_ff == 16'd1) begin
                        stat2_in = db;
                     end
                     cnt_in = cnt_inc;
                     if (cnt_inc >= slen) begin
                        cnt_in   = 16'd0;
                        phase_in = PH_CLOSE;
                     end
                  end
               endcase
            end
         end
         default: phase_in = PH_HUNT;
      endcase

      if (verdict) begin
         phase_in         = PH_HUNT;
         esc_in           = 1'b0;
         cnt_in           = 16'd0;
         res_valid        = 1'b1;
         res.out_kind     = KIND_VERDICT;
         res.reg_data     = reg_word_in;
         res.response_ok  = (code == ERR_NONE);
         res.error_code   = code;
         res.error_detail = stat2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         esc_ff      <= 1'b0;
         cnt_ff      <= 16'd0;
         dir_ff      <= 8'h00;
         opc_ff      <= 8'h00;
         len_ff      <= 16'h0000;
         reg_word_ff <= 32'h00000000;
         stat1_ff    <= 8'h00;
         stat2_ff    <= 8'h00;
         rom_ff      <= 1'b0;
         short_ff    <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         esc_ff      <= esc_in;
         cnt_ff      <= cnt_in;
         dir_ff      <= dir_in;
         opc_ff      <= opc_in;
         len_ff      <= len_in;
         reg_word_ff <= reg_word_in;
         stat1_ff    <= stat1_in;
         stat2_ff    <= stat2_in;
         rom_ff      <= rom_in;
         short_ff    <= short_in;
      end
   end

endmodule

// File: src/slip_response_frame_parser.sv
// Top level of the SLIP response frame parser.
//
// Usage: raw serial bytes enter one per beat on req_bus (valid/ready). The
// parser skips to a 0xC0 start, unescapes, reads the 8-byte header, emits
// each payload byte as a beat on rsp_bus with out_kind 0, reads the 2- or
// 4-byte status, waits for the closing 0xC0 and emits one verdict beat with
// out_kind 1. Bad escapes and short lengths end the frame early with a verdict.
// Throughput: one byte per cycle unless rsp_bus.ready stalls. Path: a byte
// accepted into the input register is processed by the core and its result
// loaded into the result register, from which the result beat is taken.
// Bytes that give no result still take one slot in the pipe.
// Stall: when rsp_bus.ready is low the result register holds, then the input
// register fills and req_bus.ready drops; nothing is lost or repeated.
// Reset (synchronous, active high) empties both registers, returns to the
// start-delimiter hunt, clears the sticky short-status flag and the CSRs.
// CSRs (APB): 0x0 expected opcode (8 = sync), 0x4 stub running (bit 0).
// Write them only while no frame bytes are in flight.
`timescale 1ns / 1ps

module slip_response_frame_parser
   import srfp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   srfp_req_if.sink                  req_bus,
   srfp_rsp_if.source                rsp_bus,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   cfg_type    cfg;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff;
   logic       advance;
   logic       step;
   logic       res_valid;
   rsp_type    res;

   srfp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   srfp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_byte   (in_byte_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   // result register free or being drained this cycle
   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign step          = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_bus.valid && req_bus.ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = advance ? (step && res_valid) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.rx_byte;
      end
      if (advance) begin
         rsp_ff <= res;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.out_kind     = rsp_ff.out_kind;
   assign rsp_bus.payload_byte = rsp_ff.payload_byte;
   assign rsp_bus.reg_data     = rsp_ff.reg_data;
   assign rsp_bus.response_ok  = rsp_ff.response_ok;
   assign rsp_bus.error_code   = rsp_ff.error_code;
   assign rsp_bus.error_detail = rsp_ff.error_detail;

endmodule

// File: src/srfp_checker.sv
// Port-level checks on the result channel, bound to the parser top level.
`timescale 1ns / 1ps

module srfp_checker
   import srfp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_out_kind,
   input logic [7:0]  rsp_payload_byte,
   input logic [31:0] rsp_reg_data,
   input logic        rsp_response_ok,
   input logic [2:0]  rsp_error_code,
   input logic [7:0]  rsp_error_detail
);

   // stalled beat keeps its payload
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_kind)
         && $stable(rsp_payload_byte) && $stable(rsp_reg_data)
         && $stable(rsp_error_code) && $stable(rsp_error_detail))
      else $error("result beat changed while stalled");

   a_verdict_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == KIND_VERDICT
         |-> rsp_response_ok == (rsp_error_code == ERR_NONE)
            && rsp_error_code <= ERR_SHORT_LEN)
      else $error("verdict ok flag disagrees with error code");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == KIND_PAYLOAD
         |-> rsp_reg_data == 32'h0 && !rsp_response_ok
            && rsp_error_code == ERR_NONE && rsp_error_detail == 8'h0)
      else $error("payload beat carries verdict fields");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind slip_response_frame_parser srfp_checker u_srfp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_out_kind     (rsp_bus.out_kind),
   .rsp_payload_byte (rsp_bus.payload_byte),
   .rsp_reg_data     (rsp_bus.reg_data),
   .rsp_response_ok  (rsp_bus.response_ok),
   .rsp_error_code   (rsp_bus.error_code),
   .rsp_error_detail (rsp_bus.error_detail)
);

// File: dv/srfp_checker.sv
// Checker for the SLIP response frame parser: predicts every result beat and compares it.
`timescale 1ns / 1ps

module srfp_tb_checker
   import srfp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   srfp_req_if                       req_mon,
   srfp_rsp_if                       rsp_mon,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   input  logic                      pready,
   output int                        fail_count,
   output int                        pending_count
);

   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_EXPECTED_OPCODE =
      CSR_ADDR_WIDTH'(4 * REG_EXPECTED_OPCODE);
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_STUB_RUNNING =
      CSR_ADDR_WIDTH'(4 * REG_STUB_RUNNING);

   typedef enum logic [2:0] {HUNT, HEADER, PAYLOAD, STATUS, CLOSING} parse_phase_type;

   cfg_type         cfg;
   parse_phase_type parse_phase;
   logic            esc_pending;
   logic [15:0]     byte_cnt;
   logic [7:0]      hdr_dir;
   logic [7:0]      hdr_opcode;
   logic [15:0]     hdr_length;
   logic [31:0]     hdr_reg;
   logic [7:0]      status_b0;
   logic [7:0]      status_b1;
   logic            short_rom;
   logic            short_status;
   rsp_type         expected_beats[$];

   function automatic logic [15:0] status_bytes();
      return short_status ? 16'd2 : 16'd4;
   endfunction

   task automatic push_verdict(input logic [2:0] code);
      rsp_type beat;
      beat = '0;
      beat.out_kind     = KIND_VERDICT;
      beat.reg_data     = hdr_reg;
      beat.response_ok  = (code == ERR_NONE);
      beat.error_code   = code;
      beat.error_detail = status_b1;
      expected_beats.push_back(beat);
      parse_phase = HUNT;
      esc_pending = 1'b0;
      byte_cnt    = '0;
   endtask

   task automatic parse_byte(input logic [7:0] raw);
      logic [7:0] b;
      logic [2:0] code;
      rsp_type    beat;
      b = raw;
      case (parse_phase)
         HUNT: begin
            if (b == SLIP_END) begin
               parse_phase = HEADER;
               esc_pending = 1'b0;
               byte_cnt    = '0;
               hdr_dir     = '0;
               hdr_opcode  = '0;
               hdr_length  = '0;
               hdr_reg     = '0;
               status_b0   = '0;
               status_b1   = '0;
            end
         end
         CLOSING: begin
            // raw bytes until the closing delimiter, no unescaping here
            if (b == SLIP_END) begin
               if (hdr_dir != DIR_RESPONSE)
                  code = ERR_DIRECTION;
               else if (hdr_opcode != cfg.expected_opcode)
                  code = ERR_OPCODE;
               else if (status_b0 != 8'h00 || status_b1 != 8'h00)
                  code = ERR_STATUS;
               else
                  code = ERR_NONE;
               push_verdict(code);
            end
         end
         default: begin
            if (esc_pending) begin
               esc_pending = 1'b0;
               if (b == SLIP_ESC_ESC)
                  b = SLIP_ESC;
               else if (b == SLIP_ESC_END)
                  b = SLIP_END;
               else begin
                  push_verdict(ERR_ESCAPE);
                  return;
               end
            end else if (b == SLIP_ESC) begin
               esc_pending = 1'b1;
               return;
            end
            case (parse_phase)
               HEADER: begin
                  case (byte_cnt)
                     16'd0: hdr_dir = b;
                     16'd1: hdr_opcode = b;
                     16'd2: hdr_length[7:0] = b;
                     16'd3: hdr_length[15:8] = b;
                     default: hdr_reg[8*byte_cnt[1:0] +: 8] = b;
                  endcase
                  byte_cnt++;
                  if (byte_cnt == 16'd8) begin
                     byte_cnt     = '0;
                     short_status = cfg.stub_running | short_rom;
                     // sync reply shorter than the status reveals the short-status ROM
                     if (cfg.expected_opcode == OPC_SYNC && hdr_length < status_bytes()) begin
                        short_rom    = 1'b1;
                        short_status = 1'b1;
                     end
                     if (hdr_length < status_bytes())
                        push_verdict(ERR_SHORT_LEN);
                     else if (hdr_length == status_bytes())
                        parse_phase = STATUS;
                     else
                        parse_phase = PAYLOAD;
                  end
               end
               PAYLOAD: begin
                  byte_cnt++;
                  if (byte_cnt >= hdr_length - status_bytes()) begin
                     byte_cnt    = '0;
                     parse_phase = STATUS;
                  end
                  beat = '0;
                  beat.out_kind     = KIND_PAYLOAD;
                  beat.payload_byte = b;
                  expected_beats.push_back(beat);
               end
               default: begin
                  if (byte_cnt == 16'd0)
                     status_b0 = b;
                  else if (byte_cnt == 16'd1)
                     status_b1 = b;
                  byte_cnt++;
                  if (byte_cnt >= status_bytes()) begin
                     byte_cnt    = '0;
                     parse_phase = CLOSING;
                  end
               end
            endcase
         end
      endcase
   endtask

   task automatic show_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got)
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         cfg          = '0;
         parse_phase  = HUNT;
         esc_pending  = 1'b0;
         byte_cnt     = '0;
         hdr_dir      = '0;
         hdr_opcode   = '0;
         hdr_length   = '0;
         hdr_reg      = '0;
         status_b0    = '0;
         status_b1    = '0;
         short_rom    = 1'b0;
         short_status = 1'b0;
         expected_beats.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == ADDR_EXPECTED_OPCODE)
               cfg.expected_opcode = pwdata[7:0];
            else if (paddr == ADDR_STUB_RUNNING)
               cfg.stub_running = pwdata[0];
         end
         if (req_mon.valid && req_mon.ready)
            parse_byte(req_mon.rx_byte);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.out_kind     = rsp_mon.out_kind;
            got.payload_byte = rsp_mon.payload_byte;
            got.reg_data     = rsp_mon.reg_data;
            got.response_ok  = rsp_mon.response_ok;
            got.error_code   = rsp_mon.error_code;
            got.error_detail = rsp_mon.error_detail;
            if (expected_beats.size() == 0) begin
               $display("%0t: unexpected result beat, expected none actual %h", $time, got);
               fail_count++;
            end else begin
               want = expected_beats.pop_front();
               if (got !== want) begin
                  fail_count++;
                  show_field("out_kind", 32'(want.out_kind), 32'(got.out_kind));
                  show_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
                  show_field("reg_data", want.reg_data, got.reg_data);
                  show_field("response_ok", 32'(want.response_ok), 32'(got.response_ok));
                  show_field("error_code", 32'(want.error_code), 32'(got.error_code));
                  show_field("error_detail", 32'(want.error_detail), 32'(got.error_detail));
               end
            end
         end
      end
      pending_count = expected_beats.size();
   end

endmodule

// File: dv/tb_slip_response_frame_parser.sv
// Testbench top for the SLIP response frame parser: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_slip_response_frame_parser;
   import srfp_pkg::*;

   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_EXPECTED_OPCODE =
      CSR_ADDR_WIDTH'(4 * REG_EXPECTED_OPCODE);
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_STUB_RUNNING =
      CSR_ADDR_WIDTH'(4 * REG_STUB_RUNNING);
   localparam logic [7:0] OPC_READ_REG    = 8'h0A;
   localparam int         HOLD_OFF_CYCLES = 400;
   localparam int         BYTES_PER_PHASE = 180;
   localparam int         NUM_PHASES      = 6;
   localparam int         CYCLE_LIMIT     = 400000;

   logic                      clock;
   logic                      reset;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [31:0]               csr_pwdata;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;
   int                        fail_count;
   int                        pending_count;
   int                        cycle_count = 0;

   srfp_req_if req_ch ();
   srfp_rsp_if rsp_ch ();

   slip_response_frame_parser DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready)
   );

   srfp_tb_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .psel          (csr_psel),
      .penable       (csr_penable),
      .pwrite        (csr_pwrite),
      .paddr         (csr_paddr),
      .pwdata        (csr_pwdata),
      .pready        (csr_pready),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // stimulus-side view of the config, used only to shape well-formed frames
   logic [7:0] cfg_opcode = '0;
   logic       cfg_stub = 1'b0;
   logic       rom_hint = 1'b0;
   bit         hold_off_req = 1'b0;
   bit         steady = 1'b0;
   int         burst_left = 0;
   int         bytes_sent = 0;
   logic [7:0] tx_bytes[$];
   int         frame_pos;
   int         frame_bad_at;
   bit         frame_aborted;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver: stall patterns that change at random, plus a long hold-off whenever one is requested
   initial begin
      int   mode;
      int   mode_left;
      logic rdy;
      mode = 0;
      mode_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (mode)
               0: rdy = 1'b1;
               1: rdy = 1'($urandom_range(0, 1));
               2: rdy = ($urandom_range(0, 3) == 0);
               default: rdy = ($urandom_range(0, 7) != 0);
            endcase
            rsp_ch.ready <= rdy;
         end
      end
   end

   function automatic logic [7:0] junk_byte();
      logic [7:0] v;
      if ($urandom_range(0, 3) == 0)
         return SLIP_ESC;
      do v = 8'($urandom); while (v == SLIP_END);
      return v;
   endfunction

   function automatic logic [7:0] biased_byte();
      case ($urandom_range(0, 7))
         0: return SLIP_END;
         1: return SLIP_ESC;
         default: return 8'($urandom);
      endcase
   endfunction

   task send_byte(input logic [7:0] b);
      int gap;
      if (!steady && burst_left == 0) begin
         gap = $urandom_range(1, 8);
         burst_left = $urandom_range(1, 40);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left > 0)
         burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task send_queued();
      while (tx_bytes.size() != 0)
         send_byte(tx_bytes.pop_front());
   endtask

   // wait until the parser is empty: pipe latency, outstanding results, then latency again
   task settle();
      req_ch.valid <= 1'b0;
      repeat (4) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task csr_write(input logic [CSR_ADDR_WIDTH-1:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (addr == ADDR_EXPECTED_OPCODE)
         cfg_opcode = data[7:0];
      else if (addr == ADDR_STUB_RUNNING)
         cfg_stub = data[0];
      @(posedge clock);
   endtask

   // escapes one data byte; at the chosen position a broken escape ends the frame
   task put_data(input logic [7:0] b);
      logic [7:0] bad;
      if (frame_aborted)
         return;
      if (frame_pos == frame_bad_at) begin
         do bad = 8'($urandom); while (bad == SLIP_ESC_ESC || bad == SLIP_ESC_END);
         tx_bytes.push_back(SLIP_ESC);
         tx_bytes.push_back(bad);
         frame_aborted = 1'b1;
      end else if (b == SLIP_END && $urandom_range(0, 3) != 0) begin
         tx_bytes.push_back(SLIP_ESC);
         tx_bytes.push_back(SLIP_ESC_END);
      end else if (b == SLIP_ESC) begin
         tx_bytes.push_back(SLIP_ESC);
         tx_bytes.push_back(SLIP_ESC_ESC);
      end else begin
         tx_bytes.push_back(b); // raw 0xC0 here is data to the parser
      end
      frame_pos++;
   endtask

   task queue_frame(input logic [7:0] dir, input logic [7:0] opc, input logic [15:0] len,
                    input logic [31:0] regv, input logic [7:0] st0, input logic [7:0] st1,
                    input int bad_at, input bit closed);
      int slen;
      slen = (cfg_stub || rom_hint) ? 2 : 4;
      frame_pos = 0;
      frame_bad_at = bad_at;
      frame_aborted = 1'b0;
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 2)) tx_bytes.push_back(junk_byte());
      tx_bytes.push_back(SLIP_END);
      put_data(dir);
      put_data(opc);
      put_data(len[7:0]);
      put_data(len[15:8]);
      for (int k = 0; k < 4; k++)
         put_data(regv[8*k +: 8]);
      if (frame_aborted)
         return;
      if (int'(len) < slen) begin
         if (cfg_opcode == OPC_SYNC)
            rom_hint = 1'b1;
         return;
      end
      for (int k = 0; k < int'(len) - slen && !frame_aborted; k++)
         put_data(biased_byte());
      put_data(st0);
      put_data(st1);
      if (slen == 4) begin
         put_data(8'($urandom));
         put_data(8'($urandom));
      end
      if (frame_aborted)
         return;
      repeat ($urandom_range(0, 2)) tx_bytes.push_back(junk_byte());
      if (closed)
         tx_bytes.push_back(SLIP_END);
   endtask

   task random_frame();
      int         slen;
      int         sel;
      int         bad_at;
      logic [7:0] dir;
      logic [7:0] opc;
      logic [7:0] st0;
      logic [7:0] st1;
      logic [15:0] len;
      if ($urandom_range(0, 99) < 6) begin
         repeat ($urandom_range(1, 5))
            tx_bytes.push_back(($urandom_range(0, 3) == 0) ? SLIP_END : junk_byte());
      end else begin
         slen = (cfg_stub || rom_hint) ? 2 : 4;
         dir = ($urandom_range(0, 9) == 0) ? 8'($urandom) : DIR_RESPONSE;
         opc = ($urandom_range(0, 7) == 0) ? 8'($urandom) : cfg_opcode;
         st0 = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'h00;
         st1 = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'h00;
         bad_at = -1;
         sel = $urandom_range(0, 99);
         if (sel < 75)
            len = 16'(slen + $urandom_range(0, 10));
         else if (sel < 82)
            len = 16'(slen + $urandom_range(11, 48));
         else if (sel < 92)
            len = 16'($urandom_range(0, slen - 1));
         else begin
            // any length, cut short by a broken escape
            len = 16'($urandom);
            bad_at = $urandom_range(0, 20);
         end
         if ($urandom_range(0, 29) == 0)
            bad_at = $urandom_range(0, 20);
         queue_frame(dir, opc, len, $urandom, st0, st1, bad_at, $urandom_range(0, 24) != 0);
      end
      send_queued();
   endtask

   initial begin
      int         target;
      logic [7:0] opc;
      reset = 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.rx_byte <= 8'h00;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_write(ADDR_EXPECTED_OPCODE, 32'(OPC_READ_REG));
      csr_write(ADDR_STUB_RUNNING, 32'd0);

      // directed frames, 4-byte status
      queue_frame(DIR_RESPONSE, OPC_READ_REG, 16'd7, 32'hC0C0_C0DB, 8'h00, 8'h00, -1, 1'b1);
      queue_frame(DIR_RESPONSE, OPC_READ_REG, 16'd4, 32'hFFFF_FFFF, 8'h00, 8'h00, -1, 1'b1);
      queue_frame(DIR_RESPONSE, OPC_READ_REG, 16'd20, 32'h0000_0000, 8'h00, 8'h00, -1, 1'b1);
      // bad direction outranks opcode and status faults
      queue_frame(8'h00, 8'h0B, 16'd6, 32'h1234_5678, 8'h01, 8'h02, -1, 1'b1);
      queue_frame(DIR_RESPONSE, 8'h00, 16'd5, 32'h8000_0001, 8'h03, 8'h00, -1, 1'b1);
      queue_frame(DIR_RESPONSE, OPC_READ_REG, 16'd5, 32'h5555_AAAA, 8'h00, 8'hFF, -1, 1'b1);
      queue_frame(DIR_RESPONSE, OPC_READ_REG, 16'd5, 32'hAAAA_5555, 8'h80, 8'h00, -1, 1'b1);
      queue_frame(8'hFF, 8'hFF, 16'd4, 32'h7FFF_FFFF, 8'hFF, 8'hFF, -1, 1'b1);
      // broken escape right after the start, in the payload, in the status
      queue_frame(DIR_RESPONSE, OPC_READ_REG, 16'd6, 32'hDBDB_DBDB, 8'h00, 8'h00, 0, 1'b1);
      queue_frame(DIR_RESPONSE, OPC_READ_REG, 16'd6, 32'h0102_0304, 8'h00, 8'h00, 9, 1'b1);
      queue_frame(DIR_RESPONSE, OPC_READ_REG, 16'd6, 32'h0506_0708, 8'h00, 8'h00, 12, 1'b1);
      // lengths below the status, then a huge length cut short by a broken escape
      queue_frame(DIR_RESPONSE, OPC_READ_REG, 16'd3, 32'hCAFE_F00D, 8'h00, 8'h00, -1, 1'b1);
      queue_frame(DIR_RESPONSE, OPC_READ_REG, 16'd0, 32'h0BAD_BEEF, 8'h00, 8'h00, -1, 1'b1);
      queue_frame(DIR_RESPONSE, OPC_READ_REG, 16'hFFFF, 32'h1357_9BDF, 8'h00, 8'h00, 12, 1'b1);
      send_queued();
      settle();

      for (int i = 0; i < NUM_PHASES; i++) begin
         case (i)
            0: opc = OPC_READ_REG;
            1: opc = 8'h00;
            2: opc = 8'hFF;
            4: opc = 8'($urandom);
            default: opc = OPC_SYNC;
         endcase
         csr_write(ADDR_EXPECTED_OPCODE, 32'(opc));
         csr_write(ADDR_STUB_RUNNING, (i == 2 || i == 5) ? 32'd1 : 32'd0);
         steady = (i == 2);
         if (i == 1 || i == 4)
            hold_off_req = 1'b1;
         target = bytes_sent + BYTES_PER_PHASE;
         while (bytes_sent < target)
            random_frame();
         settle();
      end

      if (fail_count == 0 && pending_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: filelist.f
src/srfp_pkg.sv
src/srfp_if.sv
src/srfp_csr.sv
src/srfp_core.sv
src/slip_response_frame_parser.sv
src/srfp_checker.sv
dv/srfp_checker.sv
dv/tb_slip_response_frame_parser.sv
